[rtl/dti_pkg.sv]
// Shared types and constants of the discrete-time integrator.
package dti_pkg;

  localparam int DATA_WIDTH    = 32;
  localparam int FRAC_BITS_DEF = 24;
  localparam int APB_ADDR_W    = 5;
  localparam int REG_IDX_LSB   = 2;
  localparam int REG_IDX_W     = APB_ADDR_W - REG_IDX_LSB;

  typedef enum logic [1:0] {
    METH_FWD  = 2'd0,
    METH_BWD  = 2'd1,
    METH_TRAP = 2'd2
  } method_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_METHOD      = 3'd0,
    REG_SAMPLE_TIME = 3'd1,
    REG_UPPER_LIMIT = 3'd2,
    REG_START_VALUE = 3'd3,
    REG_RESET_MODE  = 3'd4
  } reg_idx_e;

  localparam logic [1:0]            METHOD_RST      = 2'd0;
  localparam logic [DATA_WIDTH-1:0] SAMPLE_TIME_RST = 32'h0100_0000;
  localparam logic [DATA_WIDTH-1:0] UPPER_LIMIT_RST = 32'h7fff_ffff;
  localparam logic [DATA_WIDTH-1:0] START_VALUE_RST = 32'h0000_0000;
  localparam logic                  RESET_MODE_RST  = 1'b1;

  typedef struct packed {
    logic [1:0]                   method;
    logic signed [DATA_WIDTH-1:0] sample_time;
    logic signed [DATA_WIDTH-1:0] upper_limit;
    logic signed [DATA_WIDTH-1:0] start_value;
    logic                         reset_mode;
  } cfg_t;

endpackage

[rtl/discrete_time_integrator.sv]
// Discrete-time integrator: forward/backward Euler or trapezoidal, with limit and wrap.
//
// Input channel (in_valid_i/in_ready_o) carries one word per tick: enable_i,
// clear_req_i and the signed Q sample_i. Output channel (out_valid_o/out_ready_i)
// returns one word, integral_o, for every input word, in order.
// A word is captured in an input register, the whole step (one 32x32 multiply,
// the adds, limit compare and wrap) runs between that register and the
// result register, and the integrator state updates in the same cycle.
// An accepted word passes the input register and then the result register.
// Throughput: one word per cycle while the output is not stalled; the state
// feedback through the multiply-add is combinational into the state registers.
// When the receiver stalls, the result register holds its word and the input
// register holds one more; in_ready_o drops only when both are full.
// Reset clears the state (last output, history, first-step flag), empties both
// registers and loads the configuration registers with their defaults.
// Configuration is written over the APB port, register i at byte address 4*i; the
// user must write it only while no word is in flight, the block does not enforce it.
module discrete_time_integrator #(
  parameter int FRAC_BITS = dti_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   enable_i,
  input  logic                                   clear_req_i,
  input  logic signed [dti_pkg::DATA_WIDTH-1:0]  sample_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [dti_pkg::DATA_WIDTH-1:0]  integral_o,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [dti_pkg::APB_ADDR_W-1:0]         paddr,
  input  logic [dti_pkg::DATA_WIDTH-1:0]         pwdata,
  output logic [dti_pkg::DATA_WIDTH-1:0]         prdata,
  output logic                                   pready
);

  localparam int DW = dti_pkg::DATA_WIDTH;
  localparam logic [DW-1:0] FRAC_MASK = (DW'(1) << FRAC_BITS) - DW'(1);

  dti_pkg::cfg_t cfg;

  dti_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register
  logic                 in_valid_q;
  logic                 enable_q;
  logic                 clear_q;
  logic signed [DW-1:0] sample_q;

  // result register
  logic                 out_valid_q;
  logic signed [DW-1:0] integral_q;

  // integrator state
  logic signed [DW-1:0] last_out_q, last_out_d;
  logic signed [DW-1:0] hist_in_q, hist_in_d;
  logic signed [DW-1:0] hist_out_q, hist_out_d;
  logic                 started_q, started_d;

  logic                   out_free;
  logic                   step;
  logic signed [DW-1:0]   mul_a;
  logic signed [DW-1:0]   mul_b;
  logic signed [2*DW-1:0] prod;
  logic signed [DW-1:0]   inc;
  logic signed [DW-1:0]   sum;
  logic signed [DW-1:0]   sum_first;
  logic        [DW-1:0]   frac_low;
  logic signed [DW-1:0]   sum_rem;
  logic signed [DW-1:0]   y;
  logic                   saturated;

  assign out_free    = !out_valid_q || out_ready_i;
  assign step        = in_valid_q && out_free;
  assign in_ready_o  = !in_valid_q || out_free;
  assign out_valid_o = out_valid_q;
  assign integral_o  = integral_q;

  always_comb begin
    case (cfg.method)
      dti_pkg::METH_BWD: begin
        mul_a = cfg.sample_time;
        mul_b = sample_q;
      end
      dti_pkg::METH_TRAP: begin
        mul_a = cfg.sample_time >>> 1;
        mul_b = hist_in_q + sample_q;
      end
      default: begin
        mul_a = cfg.sample_time;
        mul_b = hist_in_q;
      end
    endcase
  end

  assign prod      = mul_a * mul_b;
  assign inc       = $signed(prod[FRAC_BITS +: DW]);
  assign sum       = hist_out_q + inc;
  assign sum_first = sum + cfg.start_value;
  assign frac_low  = sum & FRAC_MASK;
  assign sum_rem   = (sum[DW-1] && (frac_low != '0)) ? $signed(frac_low | ~FRAC_MASK)
                                                     : $signed(frac_low);
  assign saturated = (last_out_q >= cfg.upper_limit) && !clear_q;

  always_comb begin
    last_out_d = last_out_q;
    hist_in_d  = hist_in_q;
    hist_out_d = hist_out_q;
    started_d  = started_q;
    y          = sum;
    if (!enable_q) begin
      last_out_d = '0;
      hist_in_d  = '0;
      hist_out_d = '0;
      started_d  = 1'b0;
    end else begin
      case (cfg.method)
        dti_pkg::METH_FWD, dti_pkg::METH_BWD, dti_pkg::METH_TRAP: begin
          if (saturated) begin
            last_out_d = cfg.upper_limit;
          end else begin
            if (!started_q) begin
              y         = sum_first;
              started_d = 1'b1;
              if (cfg.method != dti_pkg::METH_BWD) begin
                hist_in_d = sample_q;
              end
            end else begin
              y         = cfg.reset_mode ? sum : sum_rem;
              hist_in_d = sample_q;
            end
            hist_out_d = y;
            last_out_d = y;
          end
          if (clear_q && cfg.reset_mode) begin
            hist_in_d  = '0;
            hist_out_d = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_out_q  <= '0;
      hist_in_q   <= '0;
      hist_out_q  <= '0;
      started_q   <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (step) begin
        last_out_q <= last_out_d;
        hist_in_q  <= hist_in_d;
        hist_out_q <= hist_out_d;
        started_q  <= started_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      enable_q <= enable_i;
      clear_q  <= clear_req_i;
      sample_q <= sample_i;
    end
    if (step) begin
      integral_q <= last_out_d;
    end
  end

endmodule

[rtl/dti_regs.sv]
// APB configuration register file of the discrete-time integrator.
module dti_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dti_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [dti_pkg::DATA_WIDTH-1:0]    pwdata,
  output logic [dti_pkg::DATA_WIDTH-1:0]    prdata,
  output logic                              pready,
  output dti_pkg::cfg_t                     cfg_o
);

  dti_pkg::cfg_t                        cfg_q;
  logic [dti_pkg::REG_IDX_W-1:0]        reg_idx;
  logic                                 wr_en;

  assign reg_idx = paddr[dti_pkg::APB_ADDR_W-1:dti_pkg::REG_IDX_LSB];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.method      <= dti_pkg::METHOD_RST;
      cfg_q.sample_time <= dti_pkg::SAMPLE_TIME_RST;
      cfg_q.upper_limit <= dti_pkg::UPPER_LIMIT_RST;
      cfg_q.start_value <= dti_pkg::START_VALUE_RST;
      cfg_q.reset_mode  <= dti_pkg::RESET_MODE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        dti_pkg::REG_METHOD:      cfg_q.method      <= pwdata[1:0];
        dti_pkg::REG_SAMPLE_TIME: cfg_q.sample_time <= pwdata;
        dti_pkg::REG_UPPER_LIMIT: cfg_q.upper_limit <= pwdata;
        dti_pkg::REG_START_VALUE: cfg_q.start_value <= pwdata;
        dti_pkg::REG_RESET_MODE:  cfg_q.reset_mode  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dti_pkg::REG_METHOD:
        prdata = {{(dti_pkg::DATA_WIDTH-2){1'b0}}, cfg_q.method};
      dti_pkg::REG_SAMPLE_TIME: prdata = cfg_q.sample_time;
      dti_pkg::REG_UPPER_LIMIT: prdata = cfg_q.upper_limit;
      dti_pkg::REG_START_VALUE: prdata = cfg_q.start_value;
      dti_pkg::REG_RESET_MODE:
        prdata = {{(dti_pkg::DATA_WIDTH-1){1'b0}}, cfg_q.reset_mode};
      default: prdata = '0;
    endcase
  end

endmodule

[rtl/dti_checker.sv]
// Port-level checks of the discrete-time integrator, bound to the top level.
module dti_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_ready_o,
  input logic                                  enable_i,
  input logic                                  out_valid_o,
  input logic                                  out_ready_i,
  input logic signed [dti_pkg::DATA_WIDTH-1:0] integral_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(integral_o))
    else $error("result word changed while stalled");

  // the input side backs up only behind a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input not ready without an output stall");

  // a fresh result follows an accepted input word, through the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result word without an accepted input word");

  // a disabled step yields zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && $past(in_valid_i && in_ready_o && !enable_i, 2)
      |-> integral_o == '0)
    else $error("disabled step gave a non-zero result");

endmodule

bind discrete_time_integrator dti_checker u_dti_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .enable_i    (enable_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .integral_o  (integral_o)
);
